### hw/rtl/assert_macros.svh
// Assertion helpers, included by the table core.
// LCA_ASSERT_RST: checked only while reset is released.
// LCA_ASSERT_CLK: checked at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCA_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define LCA_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LCA_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define LCA_ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/lca_pkg.sv
`default_nettype none

package lca_pkg;

    localparam int unsigned MAX_NODES_DEF = 128;
    localparam int unsigned LBL_W         = 16;

    // item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_WALK  = 6'b000100,
        S_WSTEP = 6'b001000,
        S_LREAD = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/lca_ram.sv
`default_nettype none

module lca_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/lowest_common_ancestor_table_core.sv
// Channel | Direction | Handshake                   | Beat payload
// in      | into core | i_in_valid / o_in_stall     | i_mode, i_node_label, i_other_label
// out     | from core | o_out_valid / i_out_stall   | o_ancestor_label, o_found, o_status
//
// Start, full-table add and unused mode: from accept straight to done, then result load.
// Add: a scan of the loaded entries, one label per cycle, then done.
// Query: the scan, then a walk and a step state per parent step and a label read, then done.
// Reset is synchronous, active low; it empties the table (node count zero).
// A new beat is taken while the last result still stalls; hold in done only
// when a second result is ready behind the stalled one.
`default_nettype none
`include "assert_macros.svh"

module lowest_common_ancestor_table_core #(
    parameter int unsigned MAX_NODES = lca_pkg::MAX_NODES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_mode,
    input  wire logic [lca_pkg::LBL_W-1:0] i_node_label,
    input  wire logic [lca_pkg::LBL_W-1:0] i_other_label,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [lca_pkg::LBL_W-1:0] o_ancestor_label,
    output logic                           o_found,
    output logic      [1:0]                o_status
);

    localparam int unsigned IW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam int unsigned LW = lca_pkg::LBL_W;

    // control registers
    lca_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_pend, n_pend;
    logic            r_out_valid, n_out_valid;

    // working registers
    logic [CW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [LW-1:0] r_a, n_a;
    logic [LW-1:0] r_b, n_b;
    logic          r_is_query, n_is_query;
    logic          r_fa, n_fa;
    logic          r_fb, n_fb;
    logic [IW-1:0] r_ia, n_ia;
    logic [IW-1:0] r_ib, n_ib;
    logic [IW-1:0] r_pa, n_pa;
    logic [IW-1:0] r_pb, n_pb;
    logic          r_mover_a, n_mover_a;
    logic [LW-1:0] r_res_label, n_res_label;
    logic          r_res_found, n_res_found;
    logic [1:0]    r_res_status, n_res_status;
    logic [LW-1:0] r_out_label, n_out_label;
    logic          r_out_found, n_out_found;
    logic [1:0]    r_out_status, n_out_status;

    // memory ports
    logic          lbl_we;
    logic [IW-1:0] lbl_waddr;
    logic [LW-1:0] lbl_wdata;
    logic [IW-1:0] lbl_raddr;
    logic [LW-1:0] lbl_rdata;
    logic          par_we;
    logic [IW-1:0] par_waddr;
    logic [IW-1:0] par_wdata;
    logic [IW-1:0] par_raddr;
    logic [IW-1:0] par_rdata;

    logic          in_acc;
    logic          scan_end;
    logic [IW-1:0] cur_idx;
    logic [IW-1:0] mover_idx;

    // Node labels, one entry per loaded node.
    lca_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_NODES)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (lbl_waddr),
        .i_wdata (lbl_wdata),
        .i_raddr (lbl_raddr),
        .o_rdata (lbl_rdata)
    );

    // Parent index per node; an entry equal to its own index marks a root.
    lca_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_NODES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    assign o_in_stall  = (r_state != lca_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cur_idx     = r_count[IW-1:0];
    // scan is over once every loaded entry has been issued and compared
    assign scan_end    = (r_ptr == r_count) && !r_pend;
    // the deeper pointer (higher index) is the one that climbs
    assign mover_idx   = (r_pa > r_pb) ? r_pa : r_pb;
    assign lbl_raddr   = (r_state == lca_pkg::S_SCAN) ? r_ptr[IW-1:0] : r_pa;
    assign par_raddr   = mover_idx;

    assign o_out_valid      = r_out_valid;
    assign o_ancestor_label = r_out_label;
    assign o_found          = r_out_found;
    assign o_status         = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pend       = 1'b0;
        n_out_valid  = r_out_valid;
        n_ptr        = r_ptr;
        n_pidx       = r_pidx;
        n_a          = r_a;
        n_b          = r_b;
        n_is_query   = r_is_query;
        n_fa         = r_fa;
        n_fb         = r_fb;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_mover_a    = r_mover_a;
        n_res_label  = r_res_label;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_label  = r_out_label;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        lbl_we       = 1'b0;
        lbl_waddr    = cur_idx;
        lbl_wdata    = i_node_label;
        par_we       = 1'b0;
        par_waddr    = cur_idx;
        par_wdata    = r_fb ? r_ib : cur_idx;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lca_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_a          = i_node_label;
                    n_b          = i_other_label;
                    n_is_query   = (i_mode == lca_pkg::MODE_QUERY);
                    n_ptr        = '0;
                    n_fa         = 1'b0;
                    n_fb         = 1'b0;
                    n_res_label  = '0;
                    n_res_found  = 1'b0;
                    n_res_status = lca_pkg::ST_OK;
                    case (i_mode)
                        lca_pkg::MODE_START: begin
                            // fresh table holding only the root
                            lbl_we    = 1'b1;
                            lbl_waddr = '0;
                            par_we    = 1'b1;
                            par_waddr = '0;
                            par_wdata = '0;
                            n_count   = CW'(1);
                            n_state   = lca_pkg::S_DONE;
                        end
                        lca_pkg::MODE_ADD: begin
                            if (r_count >= CW'(MAX_NODES)) begin
                                n_res_status = lca_pkg::ST_FULL;
                                n_state      = lca_pkg::S_DONE;
                            end else begin
                                // label goes in now; parent after the scan
                                lbl_we  = 1'b1;
                                n_state = lca_pkg::S_SCAN;
                            end
                        end
                        lca_pkg::MODE_QUERY: begin
                            n_state = lca_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = lca_pkg::S_DONE;
                        end
                    endcase
                end
            end

            lca_pkg::S_SCAN: begin
                // issue one label read per cycle over the loaded entries
                if (r_ptr != r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_ptr[IW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end
                // compare last cycle's read; keep the lowest matching index
                if (r_pend) begin
                    if (r_is_query && !r_fa && (lbl_rdata == r_a)) begin
                        n_fa = 1'b1;
                        n_ia = r_pidx;
                    end
                    if (!r_fb && (lbl_rdata == r_b)) begin
                        n_fb = 1'b1;
                        n_ib = r_pidx;
                    end
                end
                if (scan_end) begin
                    if (!r_is_query) begin
                        par_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_state = lca_pkg::S_DONE;
                    end else if (r_fa && r_fb) begin
                        n_pa    = r_ia;
                        n_pb    = r_ib;
                        n_state = lca_pkg::S_WALK;
                    end else begin
                        n_res_status = lca_pkg::ST_UNKNOWN;
                        n_state      = lca_pkg::S_DONE;
                    end
                end
            end

            lca_pkg::S_WALK: begin
                // pointers meet at the deepest common ancestor
                if (r_pa == r_pb) begin
                    n_state = lca_pkg::S_LREAD;
                end else begin
                    n_mover_a = (r_pa > r_pb);
                    n_state   = lca_pkg::S_WSTEP;
                end
            end

            lca_pkg::S_WSTEP: begin
                if (par_rdata >= mover_idx) begin
                    // deeper pointer hit a root: separate trees
                    n_res_status = lca_pkg::ST_NONE;
                    n_state      = lca_pkg::S_DONE;
                end else begin
                    if (r_mover_a) begin
                        n_pa = par_rdata;
                    end else begin
                        n_pb = par_rdata;
                    end
                    n_state = lca_pkg::S_WALK;
                end
            end

            lca_pkg::S_LREAD: begin
                n_res_label  = lbl_rdata;
                n_res_found  = 1'b1;
                n_res_status = lca_pkg::ST_OK;
                n_state      = lca_pkg::S_DONE;
            end

            lca_pkg::S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_label  = r_res_label;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_state      = lca_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lca_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lca_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_pidx       <= n_pidx;
        r_a          <= n_a;
        r_b          <= n_b;
        r_is_query   <= n_is_query;
        r_fa         <= n_fa;
        r_fb         <= n_fb;
        r_ia         <= n_ia;
        r_ib         <= n_ib;
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_mover_a    <= n_mover_a;
        r_res_label  <= n_res_label;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_label  <= n_out_label;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    `LCA_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_NODES),
        "node count over table size")
    `LCA_ASSERT_RST(a_walk_in_table, i_clk, i_rst_n,
        (r_state == lca_pkg::S_WALK) |-> ((CW'(r_pa) < r_count) && (CW'(r_pb) < r_count)),
        "walk pointer outside loaded entries")
    `LCA_ASSERT_RST(a_load_from_done, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state == lca_pkg::S_DONE),
        "result loaded outside done state")
    `LCA_ASSERT_RST(a_found_ok, i_clk, i_rst_n,
        (o_out_valid && o_found) |-> (o_status == lca_pkg::ST_OK),
        "found result with error status")
    `LCA_ASSERT_CLK(a_reset_idle, i_clk,
        !i_rst_n |=> ((r_state == lca_pkg::S_IDLE) && !o_out_valid),
        "core not idle after reset")

endmodule

`default_nettype wire
